### rtl/kbp_pkg.sv
package kbp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int FRAME_W    = 32;
    localparam int WORD_W     = FRAME_W + 3 * COORD_W;

    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_ADD       = 2'd1;
    localparam logic [1:0] OP_EVAL      = 2'd2;
    localparam logic [1:0] OP_TRANSLATE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDEF     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] PH_U  = 2'd0;
    localparam logic [1:0] PH_Q0 = 2'd1;
    localparam logic [1:0] PH_Q2 = 2'd2;
    localparam logic [1:0] PH_Q3 = 2'd3;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

endpackage

### rtl/keyframed_cubic_bspline_path.sv
// Channel   Direction  Handshake          Payload
// s_        input      s_valid / s_ready  opcode, frame, coord_x, coord_y, coord_z
// m_        output     m_valid / m_ready  status, pos_x, pos_y, pos_z, point_count
//
// One item is taken at a time; s_ready is high only while the sequencer is idle.
// How long an item takes depends on its opcode: add and translate walk the stored
// points, and evaluate is set by the table scan, the one-bit-per-cycle divider and
// the single shared multiplier.
// Reset (aresetn low at a clock edge) empties the table; the point memory is not cleared.
// A result waits in the output register while the next item is taken and worked on.
module keyframed_cubic_bspline_path
    import kbp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [FRAME_W-1:0]        s_frame,
    input  logic signed [COORD_W-1:0] s_coord_x,
    input  logic signed [COORD_W-1:0] s_coord_y,
    input  logic signed [COORD_W-1:0] s_coord_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [COORD_W-1:0] m_pos_x,
    output logic signed [COORD_W-1:0] m_pos_y,
    output logic signed [COORD_W-1:0] m_pos_z,
    output logic [CNT_W-1:0]          m_point_count
);

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DISPATCH, S_SHIFT_RD, S_SHIFT_WR, S_ADD_WR,
        S_TR_RD, S_TR_WR, S_LAST_RD, S_LAST, S_DIV, S_DIV_END, S_M_UU, S_M_UUU,
        S_M_VV, S_M_VVV, S_W2, S_Q_MUL, S_Q_END, S_BL_RD, S_BL_X, S_BL_Y, S_BL_Z,
        S_BL_ACC, S_FIN, S_DONE
    } state_t;

    localparam int DSH_W  = 35;
    localparam int W_W    = 52;
    localparam int MUL_W  = 36;
    localparam int ACC_W  = 68;

    // floor(y / 3) is (y * RECIP3) >> 35 for every y below 2^35.
    localparam logic signed [MUL_W-1:0] RECIP3 = 36'sd11453246123;

    state_t state_reg;

    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rd_q;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    logic [1:0]                op_reg;
    logic [FRAME_W-1:0]        frame_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [CNT_W-1:0]          cnt_reg, i_reg, k_reg, wa_reg;
    logic                      new_reg;
    logic [FRAME_W-1:0]        prev_f_reg;
    logic [1:0]                status_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;

    logic [31:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [31:0]        dvs_reg;
    logic [5:0]         dstep_reg;
    logic [1:0]         phase_reg;

    logic [16:0]        u_reg;
    logic [33:0]        uu_reg;
    logic [W_W-1:0]     w3_reg, w0_reg, w2_reg;
    logic [32:0]        q0_reg, q1_reg, q2_reg, q3_reg;
    logic [1:0]         j_reg;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   accx_reg, accy_reg, accz_reg;

    logic                      m_valid_reg;
    logic [1:0]                m_status_reg;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic [CNT_W-1:0]          m_cnt_reg;

    logic [FRAME_W-1:0]        rd_frame;
    logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
    assign rd_frame = rd_q[WORD_W-1 -: FRAME_W];
    assign rd_x     = rd_q[3*COORD_W-1 -: COORD_W];
    assign rd_y     = rd_q[2*COORD_W-1 -: COORD_W];
    assign rd_z     = rd_q[COORD_W-1:0];

    logic [16:0] v_val;
    assign v_val = 17'd65536 - u_reg;

    logic [CNT_W-1:0] idx;
    always_comb begin
        case (j_reg)
            2'd0:    idx = (k_reg >= CNT_W'(2)) ? k_reg - CNT_W'(2) : '0;
            2'd1:    idx = k_reg - CNT_W'(1);
            2'd2:    idx = k_reg;
            default: idx = (k_reg + CNT_W'(1) < cnt_reg) ? k_reg + CNT_W'(1)
                                                        : cnt_reg - CNT_W'(1);
        endcase
    end

    logic [32:0]       q_sel;
    always_comb begin
        case (j_reg)
            2'd0:    q_sel = q0_reg;
            2'd1:    q_sel = q1_reg;
            2'd2:    q_sel = q2_reg;
            default: q_sel = q3_reg;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_SHIFT_RD, S_SHIFT_WR:                  rd_addr = ADDR_W'(i_reg - CNT_W'(1));
            S_LAST_RD, S_LAST:                       rd_addr = ADDR_W'(cnt_reg - CNT_W'(1));
            S_BL_RD, S_BL_X, S_BL_Y, S_BL_Z, S_BL_ACC: rd_addr = idx[ADDR_W-1:0];
            default:                                 rd_addr = i_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_reg[ADDR_W-1:0];
        wr_data = rd_q;
        case (state_reg)
            S_SHIFT_WR: begin
                wr_en = 1'b1;
            end
            S_ADD_WR: begin
                wr_en   = 1'b1;
                wr_addr = wa_reg[ADDR_W-1:0];
                wr_data = {frame_reg, cx_reg, cy_reg, cz_reg};
            end
            S_TR_WR: begin
                wr_en   = 1'b1;
                wr_data = {rd_frame, sat_add(rd_x, cx_reg), sat_add(rd_y, cy_reg),
                           sat_add(rd_z, cz_reg)};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    function automatic logic [DSH_W-1:0] round6(input logic [W_W-1:0] w);
        logic [W_W-1:0] s;
        s = w + W_W'(196608);
        round6 = s[16 +: DSH_W];
    endfunction

    logic [W_W-1:0]   w_sel;
    always_comb begin
        case (phase_reg)
            PH_Q0:   w_sel = w0_reg;
            PH_Q2:   w_sel = w2_reg;
            default: w_sel = w3_reg;
        endcase
    end

    logic [DSH_W-1:0] w_round;
    logic [32:0]      q_quot;
    assign w_round = round6(w_sel);
    assign q_quot  = prod_reg[35 +: 33];

    logic signed [MUL_W-1:0] mul_a, mul_b;
    always_comb begin
        case (state_reg)
            S_M_UU:  begin mul_a = MUL_W'(u_reg);  mul_b = MUL_W'(u_reg); end
            S_M_UUU: begin mul_a = MUL_W'(prod_reg[33:0]); mul_b = MUL_W'(u_reg); end
            S_M_VV:  begin mul_a = MUL_W'(v_val);  mul_b = MUL_W'(v_val); end
            S_M_VVV: begin mul_a = MUL_W'(prod_reg[33:0]); mul_b = MUL_W'(v_val); end
            S_Q_MUL: begin mul_a = MUL_W'(w_round[DSH_W-1:1]); mul_b = RECIP3; end
            S_BL_X:  begin mul_a = MUL_W'(q_sel);  mul_b = MUL_W'(rd_x); end
            S_BL_Y:  begin mul_a = MUL_W'(q_sel);  mul_b = MUL_W'(rd_y); end
            S_BL_Z:  begin mul_a = MUL_W'(q_sel);  mul_b = MUL_W'(rd_z); end
            default: begin mul_a = '0;             mul_b = '0; end
        endcase
        if (state_reg == S_BL_X || state_reg == S_BL_Y || state_reg == S_BL_Z) begin
            mul_b = {{(MUL_W-COORD_W){mul_b[COORD_W-1]}}, mul_b[COORD_W-1:0]};
        end
    end

    logic [32:0]      div_t;
    logic             div_ge;
    logic [32:0]      div_rem_next;
    assign div_t        = {rem_reg, 1'b0};
    assign div_ge       = (div_t >= {1'b0, dvs_reg});
    assign div_rem_next = div_ge ? div_t - {1'b0, dvs_reg} : div_t;

    logic [W_W-1:0] w2_calc;
    assign w2_calc = (W_W'(uu_reg) * W_W'(3) << 16) + (W_W'(u_reg) * W_W'(3) << 32)
                   + (W_W'(1) << 48) - w3_reg * W_W'(3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_opcode;
                        frame_reg  <= s_frame;
                        cx_reg     <= s_coord_x;
                        cy_reg     <= s_coord_y;
                        cz_reg     <= s_coord_z;
                        status_reg <= ST_OK;
                        px_reg     <= '0;
                        py_reg     <= '0;
                        pz_reg     <= '0;
                        i_reg      <= '0;
                        k_reg      <= '0;
                        new_reg    <= 1'b0;
                        case (s_opcode)
                            OP_CLEAR: begin
                                cnt_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                            OP_TRANSLATE: begin
                                state_reg <= (cnt_reg == '0) ? S_DONE : S_TR_RD;
                            end
                            default: begin
                                state_reg <= (cnt_reg == '0) ? S_DISPATCH : S_SCAN_RD;
                            end
                        endcase
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (rd_frame <= frame_reg) begin
                        prev_f_reg <= rd_frame;
                        i_reg      <= i_reg + CNT_W'(1);
                        if (i_reg + CNT_W'(1) == cnt_reg) begin
                            k_reg     <= cnt_reg;
                            state_reg <= S_DISPATCH;
                        end else begin
                            state_reg <= S_SCAN_RD;
                        end
                    end else begin
                        k_reg     <= i_reg;
                        rem_reg   <= frame_reg - prev_f_reg;
                        dvs_reg   <= rd_frame - prev_f_reg;
                        quo_reg   <= '0;
                        dstep_reg <= 6'd16;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (op_reg == OP_ADD) begin
                        if (k_reg != '0 && prev_f_reg == frame_reg) begin
                            wa_reg    <= k_reg - CNT_W'(1);
                            state_reg <= S_ADD_WR;
                        end else if (cnt_reg >= CNT_W'(MAX_POINTS)) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_DONE;
                        end else begin
                            new_reg <= 1'b1;
                            wa_reg  <= k_reg;
                            i_reg   <= cnt_reg;
                            state_reg <= (cnt_reg > k_reg) ? S_SHIFT_RD : S_ADD_WR;
                        end
                    end else begin
                        if (k_reg == '0) begin
                            status_reg <= ST_UNDEF;
                            state_reg  <= S_DONE;
                        end else if (k_reg >= cnt_reg) begin
                            state_reg <= S_LAST_RD;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    i_reg     <= i_reg - CNT_W'(1);
                    state_reg <= (i_reg - CNT_W'(1) > k_reg) ? S_SHIFT_RD : S_ADD_WR;
                end
                S_ADD_WR: begin
                    if (new_reg) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_TR_RD: begin
                    state_reg <= S_TR_WR;
                end
                S_TR_WR: begin
                    i_reg     <= i_reg + CNT_W'(1);
                    state_reg <= (i_reg + CNT_W'(1) == cnt_reg) ? S_DONE : S_TR_RD;
                end
                S_LAST_RD: begin
                    state_reg <= S_LAST;
                end
                S_LAST: begin
                    px_reg    <= rd_x;
                    py_reg    <= rd_y;
                    pz_reg    <= rd_z;
                    state_reg <= S_DONE;
                end
                S_DIV: begin
                    rem_reg   <= div_rem_next[31:0];
                    quo_reg   <= {quo_reg[14:0], div_ge};
                    dstep_reg <= dstep_reg - 6'd1;
                    if (dstep_reg == 6'd1) begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    u_reg     <= {1'b0, quo_reg};
                    state_reg <= S_M_UU;
                end
                S_M_UU: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_M_UUU;
                end
                S_M_UUU: begin
                    uu_reg    <= prod_reg[33:0];
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_M_VV;
                end
                S_M_VV: begin
                    w3_reg    <= prod_reg[W_W-1:0];
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_M_VVV;
                end
                S_M_VVV: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_W2;
                end
                S_W2: begin
                    w0_reg    <= prod_reg[W_W-1:0];
                    w2_reg    <= w2_calc;
                    phase_reg <= PH_Q0;
                    state_reg <= S_Q_MUL;
                end
                S_Q_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_Q_END;
                end
                S_Q_END: begin
                    case (phase_reg)
                        PH_Q0: begin
                            q0_reg    <= q_quot;
                            phase_reg <= PH_Q2;
                            state_reg <= S_Q_MUL;
                        end
                        PH_Q2: begin
                            q2_reg    <= q_quot;
                            phase_reg <= PH_Q3;
                            state_reg <= S_Q_MUL;
                        end
                        default: begin
                            q3_reg    <= q_quot;
                            q1_reg    <= (33'd1 << 32) - q0_reg - q2_reg - q_quot;
                            j_reg     <= 2'd0;
                            accx_reg  <= ACC_W'(64'sd2147483648);
                            accy_reg  <= ACC_W'(64'sd2147483648);
                            accz_reg  <= ACC_W'(64'sd2147483648);
                            state_reg <= S_BL_RD;
                        end
                    endcase
                end
                S_BL_RD: begin
                    state_reg <= S_BL_X;
                end
                S_BL_X: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_BL_Y;
                end
                S_BL_Y: begin
                    accx_reg  <= accx_reg + prod_reg[ACC_W-1:0];
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_BL_Z;
                end
                S_BL_Z: begin
                    accy_reg  <= accy_reg + prod_reg[ACC_W-1:0];
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_BL_ACC;
                end
                S_BL_ACC: begin
                    accz_reg <= accz_reg + prod_reg[ACC_W-1:0];
                    j_reg    <= j_reg + 2'd1;
                    state_reg <= (j_reg == 2'd3) ? S_FIN : S_BL_RD;
                end
                S_FIN: begin
                    px_reg    <= accx_reg[32 +: COORD_W];
                    py_reg    <= accy_reg[32 +: COORD_W];
                    pz_reg    <= accz_reg[32 +: COORD_W];
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_x_reg      <= px_reg;
                        m_y_reg      <= py_reg;
                        m_z_reg      <= pz_reg;
                        m_cnt_reg    <= cnt_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_pos_x       = m_x_reg;
    assign m_pos_y       = m_y_reg;
    assign m_pos_z       = m_z_reg;
    assign m_point_count = m_cnt_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("Point count exceeds table depth.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input taken again before the current item finished.");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNDEF |-> m_pos_x == '0 && m_pos_y == '0 && m_pos_z == '0)
        else $error("Undefined position carries a nonzero value.");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_point_count == CNT_W'(MAX_POINTS))
        else $error("Table full reported with free entries.");

endmodule
